FILE: rtl/anchor_spring_force_top_macros.svh
// assertion macros for the anchor spring force block
// used by anchor_spring_force_top; expects clk and rst_n in scope
`ifndef ANCHOR_SPRING_FORCE_TOP_MACROS_SVH
`define ANCHOR_SPRING_FORCE_TOP_MACROS_SVH

// same-cycle implication
`define ASF_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/asf_pkg.sv
// shared types, constants and helpers of the anchor spring force block
// no dependencies
package asf_pkg;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_XX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_XZ = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_ZX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_ZZ = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPRING = 3'd4;

    localparam logic signed [18:0] W_LIMIT = 19'sd131072;
    localparam logic [47:0] E_MAX = 48'hFFFF_FFFF_FFFF;

    // multiplier operand selections
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE    = 5'd0;
    localparam logic [OP_W-1:0] OP_SX_W    = 5'd1;
    localparam logic [OP_W-1:0] OP_SZ_W    = 5'd2;
    localparam logic [OP_W-1:0] OP_BXX_SX  = 5'd3;
    localparam logic [OP_W-1:0] OP_BXZ_SZ  = 5'd4;
    localparam logic [OP_W-1:0] OP_BZX_SX  = 5'd5;
    localparam logic [OP_W-1:0] OP_BZZ_SZ  = 5'd6;
    localparam logic [OP_W-1:0] OP_DRX_DRX = 5'd7;
    localparam logic [OP_W-1:0] OP_DRZ_DRZ = 5'd8;
    localparam logic [OP_W-1:0] OP_K_DRX   = 5'd9;
    localparam logic [OP_W-1:0] OP_K_DRZ   = 5'd10;
    localparam logic [OP_W-1:0] OP_K_LO    = 5'd11;
    localparam logic [OP_W-1:0] OP_K_HI    = 5'd12;
    localparam logic [OP_W-1:0] OP_FHX_W   = 5'd13;
    localparam logic [OP_W-1:0] OP_FLX_W   = 5'd14;
    localparam logic [OP_W-1:0] OP_FHZ_W   = 5'd15;
    localparam logic [OP_W-1:0] OP_FLZ_W   = 5'd16;

    typedef struct packed {
        logic signed [31:0] box_xx;
        logic signed [31:0] box_xz;
        logic signed [31:0] box_zx;
        logic signed [31:0] box_zz;
        logic [30:0]        spring_k;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sz;
        logic signed [18:0] w;
        logic signed [32:0] drx;
        logic signed [32:0] drz;
        logic [63:0]        n2;
        logic signed [46:0] fx;
        logic signed [46:0] fz;
    } mul_src_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (v < -66'sd2147483648)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

endpackage

FILE: rtl/asf_mul.sv
// shared 33x33 signed multiplier with operand select and registered product
// depends on asf_pkg
module asf_mul
    import asf_pkg::*;
(
    input  logic                clk,
    input  logic [OP_W-1:0]     op,
    input  mul_src_t            src,
    input  cfg_t                cfg,
    output logic signed [65:0]  prod
);

    logic signed [32:0] opa;
    logic signed [32:0] opb;
    logic signed [32:0] w_ext;
    logic signed [32:0] k_ext;
    logic signed [65:0] prod_next;
    logic signed [65:0] prod_reg;

    assign w_ext = {{14{src.w[18]}}, src.w};
    assign k_ext = {2'b00, cfg.spring_k};

    always_comb
    begin
        unique case (op)
            OP_SX_W:    begin opa = {src.sx[31], src.sx}; opb = w_ext; end
            OP_SZ_W:    begin opa = {src.sz[31], src.sz}; opb = w_ext; end
            OP_BXX_SX:  begin opa = {cfg.box_xx[31], cfg.box_xx}; opb = {src.sx[31], src.sx}; end
            OP_BXZ_SZ:  begin opa = {cfg.box_xz[31], cfg.box_xz}; opb = {src.sz[31], src.sz}; end
            OP_BZX_SX:  begin opa = {cfg.box_zx[31], cfg.box_zx}; opb = {src.sx[31], src.sx}; end
            OP_BZZ_SZ:  begin opa = {cfg.box_zz[31], cfg.box_zz}; opb = {src.sz[31], src.sz}; end
            OP_DRX_DRX: begin opa = src.drx; opb = src.drx; end
            OP_DRZ_DRZ: begin opa = src.drz; opb = src.drz; end
            OP_K_DRX:   begin opa = k_ext; opb = src.drx; end
            OP_K_DRZ:   begin opa = k_ext; opb = src.drz; end
            OP_K_LO:    begin opa = k_ext; opb = {1'b0, src.n2[31:0]}; end
            OP_K_HI:    begin opa = k_ext; opb = {1'b0, src.n2[63:32]}; end
            // force split as high part times weight plus low 16 bits times weight
            OP_FHX_W:   begin opa = {{2{src.fx[46]}}, src.fx[46:16]}; opb = w_ext; end
            OP_FLX_W:   begin opa = {17'b0, src.fx[15:0]}; opb = w_ext; end
            OP_FHZ_W:   begin opa = {{2{src.fz[46]}}, src.fz[46:16]}; opb = w_ext; end
            OP_FLZ_W:   begin opa = {17'b0, src.fz[15:0]}; opb = w_ext; end
            default:    begin opa = '0; opb = '0; end
        endcase
    end

    assign prod_next = opa * opb;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/asf_cfg.sv
// configuration register file: box matrix and spring constant
// depends on asf_pkg
module asf_cfg
    import asf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_BOX_XX: cfg_next.box_xx   = cfg_data;
                REG_BOX_XZ: cfg_next.box_xz   = cfg_data;
                REG_BOX_ZX: cfg_next.box_zx   = cfg_data;
                REG_BOX_ZZ: cfg_next.box_zz   = cfg_data;
                REG_SPRING: cfg_next.spring_k = cfg_data[30:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.box_xx   <= 32'sd65536;
            cfg_reg.box_xz   <= '0;
            cfg_reg.box_zx   <= '0;
            cfg_reg.box_zz   <= 32'sd65536;
            cfg_reg.spring_k <= 31'd65536;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/anchor_spring_force_top.sv
// top level of the anchor spring force block: sequencer, state and output register
// depends on asf_pkg, asf_mul, asf_cfg and anchor_spring_force_top_macros.svh
//
// One 33x33 multiplier, shared under a small sequencer, does all products, so
// item latency is set by the count of multiplies issued in series. A node item
// is accepted, then takes two products and the sum. A complete atom is accepted,
// then runs the box mapping, the squared length, the two forces and energy,
// loads the atom result, then for each node computes its force share and loads
// that node result into the output register. An atom with a wrong node count
// goes straight from accept to loading its result. The block takes no input
// while it works on an item; the last result may still wait in the output
// register while the next item is accepted.
`include "anchor_spring_force_top_macros.svh"

module anchor_spring_force_top
    import asf_pkg::*;
#(
    parameter int NODES_PER_ELEMENT = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 is_atom,
    input  logic                 new_pass,
    input  logic [15:0]          point_index,
    input  logic signed [31:0]   pos_x,
    input  logic signed [31:0]   pos_z,
    input  logic signed [18:0]   weight,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [15:0]          point_index_res,
    output logic signed [31:0]   force_x,
    output logic signed [31:0]   force_z,
    output logic [47:0]          anchor_energy,
    output logic [47:0]          energy_total,
    output logic                 status,
    output logic                 last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int CNT_W = $clog2(NODES_PER_ELEMENT + 2);
    localparam int IDX_W = $clog2(NODES_PER_ELEMENT);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_NODE  = 3'd1;
    localparam logic [2:0] ST_ATOM  = 3'd2;
    localparam logic [2:0] ST_FORCE = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    cfg_t               cfg;
    mul_src_t           src;
    logic [OP_W-1:0]    op;
    logic signed [65:0] prod;

    logic [2:0]         state_reg, state_next;
    logic [3:0]         step_reg, step_next;
    logic [CNT_W-1:0]   node_count_reg, node_count_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [47:0]        energy_acc_reg, energy_acc_next;
    logic               out_valid_reg, out_valid_next;

    logic [31:0]        first_x_reg, first_x_next, first_z_reg, first_z_next;
    logic [31:0]        osx_reg, osx_next, osz_reg, osz_next;
    logic signed [31:0] sx_reg, sx_next, sz_reg, sz_next;
    logic signed [18:0] w_reg, w_next;
    logic signed [65:0] acc_reg, acc_next;
    logic signed [32:0] drx_reg, drx_next, drz_reg, drz_next;
    logic [63:0]        n2_reg, n2_next;
    logic signed [46:0] fx_reg, fx_next, fz_reg, fz_next;
    logic [47:0]        e_reg, e_next;
    logic [15:0]        res_idx_reg, res_idx_next;
    logic signed [31:0] res_fx_reg, res_fx_next, res_fz_reg, res_fz_next;
    logic               res_status_reg, res_status_next;
    logic               res_last_reg, res_last_next;

    logic [15:0]        out_idx_reg;
    logic signed [31:0] out_fx_reg, out_fz_reg;
    logic [47:0]        out_e_reg, out_tot_reg;
    logic               out_status_reg, out_last_reg;

    logic [15:0]        node_id_mem [NODES_PER_ELEMENT];
    logic signed [18:0] node_w_mem  [NODES_PER_ELEMENT];

    logic               node_wr;
    logic               out_load;
    logic signed [18:0] w_clamped;
    logic signed [65:0] acc_sum;
    logic signed [65:0] acc_lo_sum;
    logic [63:0]        e_full;
    logic [48:0]        e_tot_sum;

    asf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    asf_mul u_mul (
        .clk  (clk),
        .op   (op),
        .src  (src),
        .cfg  (cfg),
        .prod (prod)
    );

    assign in_ready = (state_reg == ST_IDLE);

    assign w_clamped = (weight > W_LIMIT) ? W_LIMIT :
                       (weight < -W_LIMIT) ? -W_LIMIT : weight;

    assign node_wr = in_valid && in_ready && !is_atom &&
                     (node_count_reg < CNT_W'(NODES_PER_ELEMENT));

    assign src.sx  = sx_reg;
    assign src.sz  = sz_reg;
    assign src.w   = (state_reg == ST_FORCE) ? node_w_mem[j_reg] : w_reg;
    assign src.drx = drx_reg;
    assign src.drz = drz_reg;
    assign src.n2  = n2_reg;
    assign src.fx  = fx_reg;
    assign src.fz  = fz_reg;

    // operand selection per sequencer step
    always_comb
    begin
        op = OP_NONE;
        unique case (state_reg)
            ST_NODE:
                case (step_reg)
                    4'd0:    op = OP_SX_W;
                    4'd1:    op = OP_SZ_W;
                    default: op = OP_NONE;
                endcase
            ST_ATOM:
                case (step_reg)
                    4'd0:    op = OP_BXX_SX;
                    4'd1:    op = OP_BXZ_SZ;
                    4'd2:    op = OP_BZX_SX;
                    4'd3:    op = OP_BZZ_SZ;
                    4'd4:    op = OP_DRX_DRX;
                    4'd5:    op = OP_DRZ_DRZ;
                    4'd6:    op = OP_K_DRX;
                    4'd7:    op = OP_K_DRZ;
                    4'd8:    op = OP_K_LO;
                    4'd9:    op = OP_K_HI;
                    default: op = OP_NONE;
                endcase
            ST_FORCE:
                case (step_reg)
                    4'd0:    op = OP_FHX_W;
                    4'd1:    op = OP_FLX_W;
                    4'd2:    op = OP_FHZ_W;
                    4'd3:    op = OP_FLZ_W;
                    default: op = OP_NONE;
                endcase
            default: op = OP_NONE;
        endcase
    end

    assign acc_sum    = acc_reg + prod;
    assign acc_lo_sum = acc_reg + (prod >>> 16);
    // energy = floor(K * n2 / 2^33) from the two half products
    assign e_full     = {1'b0, n2_reg[63:1]} + {33'b0, acc_reg[63:33]};
    assign e_tot_sum  = {1'b0, energy_acc_reg} + {1'b0, e_reg};

    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        node_count_next = node_count_reg;
        j_next          = j_reg;
        energy_acc_next = energy_acc_reg;
        first_x_next    = first_x_reg;
        first_z_next    = first_z_reg;
        osx_next        = osx_reg;
        osz_next        = osz_reg;
        sx_next         = sx_reg;
        sz_next         = sz_reg;
        w_next          = w_reg;
        acc_next        = acc_reg;
        drx_next        = drx_reg;
        drz_next        = drz_reg;
        n2_next         = n2_reg;
        fx_next         = fx_reg;
        fz_next         = fz_reg;
        e_next          = e_reg;
        res_idx_next    = res_idx_reg;
        res_fx_next     = res_fx_reg;
        res_fz_next     = res_fz_reg;
        res_status_next = res_status_reg;
        res_last_next   = res_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (new_pass)
                        energy_acc_next = '0;
                    step_next = '0;
                    if (!is_atom)
                    begin
                        if (node_count_reg >= CNT_W'(NODES_PER_ELEMENT))
                        begin
                            // surplus node, only marks the anchor as bad (its new_pass still clears the energy total)
                            node_count_next = CNT_W'(NODES_PER_ELEMENT + 1);
                        end
                        else
                        begin
                            if (node_count_reg == '0)
                            begin
                                first_x_next = pos_x;
                                first_z_next = pos_z;
                                osx_next     = '0;
                                osz_next     = '0;
                                sx_next      = '0;
                                sz_next      = '0;
                            end
                            else
                            begin
                                sx_next = pos_x - first_x_reg;
                                sz_next = pos_z - first_z_reg;
                            end
                            w_next          = w_clamped;
                            node_count_next = node_count_reg + 1'b1;
                            state_next      = ST_NODE;
                        end
                    end
                    else
                    begin
                        node_count_next = '0;
                        res_idx_next    = point_index;
                        j_next          = '0;
                        if (node_count_reg != CNT_W'(NODES_PER_ELEMENT))
                        begin
                            res_fx_next     = '0;
                            res_fz_next     = '0;
                            e_next          = '0;
                            res_status_next = 1'b1;
                            res_last_next   = 1'b1;
                            state_next      = ST_EMIT;
                        end
                        else
                        begin
                            sx_next    = pos_x - first_x_reg - osx_reg;
                            sz_next    = pos_z - first_z_reg - osz_reg;
                            state_next = ST_ATOM;
                        end
                    end
                end
            end

            ST_NODE:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == 4'd1)
                    osx_next = osx_reg + prod[47:16];
                else if (step_reg == 4'd2)
                begin
                    osz_next   = osz_reg + prod[47:16];
                    state_next = ST_IDLE;
                end
            end

            ST_ATOM:
            begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    4'd1:  acc_next = prod;
                    4'd2:  drx_next = acc_sum[64:32];
                    4'd3:  acc_next = prod;
                    4'd4:  drz_next = acc_sum[64:32];
                    4'd5:  n2_next  = prod[63:0];
                    4'd6:  n2_next  = n2_reg + prod[63:0];
                    4'd7:  fx_next  = prod[62:16];
                    4'd8:  fz_next  = prod[62:16];
                    4'd9:  acc_next = prod;
                    4'd10:
                    begin
                        n2_next  = prod[63:0];
                        acc_next = acc_reg + $signed({33'b0, prod[0], 32'b0});
                    end
                    4'd11:
                        e_next = (e_full > {16'b0, E_MAX}) ? E_MAX : e_full[47:0];
                    4'd12:
                    begin
                        energy_acc_next = e_tot_sum[48] ? E_MAX : e_tot_sum[47:0];
                        res_fx_next     = sat32(-$signed({{19{fx_reg[46]}}, fx_reg}));
                        res_fz_next     = sat32(-$signed({{19{fz_reg[46]}}, fz_reg}));
                        res_status_next = 1'b0;
                        res_last_next   = 1'b0;
                        state_next      = ST_EMIT;
                    end
                    default: ;
                endcase
            end

            ST_FORCE:
            begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    4'd1:  acc_next    = prod;
                    4'd2:  res_fx_next = sat32(acc_lo_sum);
                    4'd3:  acc_next    = prod;
                    4'd4:
                    begin
                        res_fz_next     = sat32(acc_lo_sum);
                        res_idx_next    = node_id_mem[j_reg];
                        res_last_next   = (j_reg == IDX_W'(NODES_PER_ELEMENT - 1));
                        res_status_next = 1'b0;
                        j_next          = j_reg + 1'b1;
                        state_next      = ST_EMIT;
                    end
                    default: ;
                endcase
            end

            ST_EMIT:
            begin
                if (out_load)
                begin
                    step_next  = '0;
                    state_next = res_last_reg ? ST_IDLE : ST_FORCE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            node_count_reg <= '0;
            j_reg          <= '0;
            energy_acc_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            node_count_reg <= node_count_next;
            j_reg          <= j_next;
            energy_acc_reg <= energy_acc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_x_reg    <= first_x_next;
        first_z_reg    <= first_z_next;
        osx_reg        <= osx_next;
        osz_reg        <= osz_next;
        sx_reg         <= sx_next;
        sz_reg         <= sz_next;
        w_reg          <= w_next;
        acc_reg        <= acc_next;
        drx_reg        <= drx_next;
        drz_reg        <= drz_next;
        n2_reg         <= n2_next;
        fx_reg         <= fx_next;
        fz_reg         <= fz_next;
        e_reg          <= e_next;
        res_idx_reg    <= res_idx_next;
        res_fx_reg     <= res_fx_next;
        res_fz_reg     <= res_fz_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
        if (node_wr)
        begin
            node_id_mem[node_count_reg[IDX_W-1:0]] <= point_index;
            node_w_mem[node_count_reg[IDX_W-1:0]]  <= w_clamped;
        end
        if (out_load)
        begin
            out_idx_reg    <= res_idx_reg;
            out_fx_reg     <= res_fx_reg;
            out_fz_reg     <= res_fz_reg;
            out_e_reg      <= e_reg;
            out_tot_reg    <= energy_acc_reg;
            out_status_reg <= res_status_reg;
            out_last_reg   <= res_last_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign point_index_res = out_idx_reg;
    assign force_x         = out_fx_reg;
    assign force_z         = out_fz_reg;
    assign anchor_energy   = out_e_reg;
    assign energy_total    = out_tot_reg;
    assign status          = out_status_reg;
    assign last            = out_last_reg;

    `ASF_ASSERT_IMPL(a_cnt_range, 1'b1, node_count_reg <= CNT_W'(NODES_PER_ELEMENT + 1), "node count out of range")
    `ASF_ASSERT_NEXT(a_atom_clears, in_valid && in_ready && is_atom, node_count_reg == '0, "atom did not close anchor")
    `ASF_ASSERT_IMPL(a_bad_result, out_valid && status, force_x == '0 && force_z == '0 && anchor_energy == '0 && last, "bad anchor result not empty")
    `ASF_ASSERT_IMPL(a_total_ge, out_valid && !status, energy_total >= anchor_energy, "energy total below anchor energy")

endmodule

FILE: sim/testbench.sv
// self-checking testbench of the anchor spring force block
// drives node and atom items, predicts forces and energies, compares every result
// depends on asf_pkg and anchor_spring_force_top
module testbench;
    import asf_pkg::*;

    localparam int NPE = 4;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic        is_atom;
        logic        new_pass;
        logic [15:0] idx;
        logic [31:0] px;
        logic [31:0] pz;
        logic [18:0] w;
    } item_t;

    typedef struct {
        logic [15:0] idx;
        logic [31:0] fx;
        logic [31:0] fz;
        logic [47:0] e;
        logic [47:0] tot;
        logic        st;
        logic        lst;
    } force_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic is_atom = 1'b0;
    logic new_pass = 1'b0;
    logic [15:0] point_index = '0;
    logic signed [31:0] pos_x = '0;
    logic signed [31:0] pos_z = '0;
    logic signed [18:0] weight = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [15:0] point_index_res;
    logic signed [31:0] force_x;
    logic signed [31:0] force_z;
    logic [47:0] anchor_energy;
    logic [47:0] energy_total;
    logic status;
    logic last;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    anchor_spring_force_top #(.NODES_PER_ELEMENT(NPE)) dut (.*);

    always #10 clk = ~clk;

    // predictor state
    longint m_bxx, m_bxz, m_bzx, m_bzz, m_k;
    logic [15:0] m_ids [NPE];
    longint m_wts [NPE];
    int m_count;
    logic [31:0] m_fx0, m_fz0;
    longint m_sumx, m_sumz;
    logic [63:0] m_eacc;

    item_t pending_items[$];
    force_t expected_forces[$];
    int errors = 0;
    int cycles = 0;
    int send_idle = 32;
    int recv_idle = 85;
    int hold_cycles = 0;
    bit send_paused = 0;

    function automatic longint fshift(longint x, int s);
        return x >>> s;
    endfunction

    function automatic logic [31:0] clamp32(longint x);
        if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (x < -64'sd2147483648) return 32'h8000_0000;
        return x[31:0];
    endfunction

    function automatic longint map_row(longint a, longint b, longint c, longint d);
        longint p1, p2;
        logic [63:0] l;
        p1 = a * b;
        p2 = c * d;
        l = {32'd0, p1[31:0]} + {32'd0, p2[31:0]};
        return fshift(p1, 32) + fshift(p2, 32) + longint'(l >> 32);
    endfunction

    task automatic predict_item(item_t it);
        longint w, sx, sz, drx, drz, fx, fz;
        logic [63:0] ax, az, n2, a, b, e;
        logic [31:0] dx, dz;
        force_t r;
        w = longint'(signed'(it.w));
        if (it.new_pass) m_eacc = 0;
        if (!it.is_atom) begin
            if (w > 131072) w = 131072;
            if (w < -131072) w = -131072;
            if (m_count >= NPE) begin
                m_count = NPE + 1;
                return;
            end
            if (m_count == 0) begin
                m_fx0 = it.px; m_fz0 = it.pz; m_sumx = 0; m_sumz = 0;
            end
            dx = it.px - m_fx0;
            dz = it.pz - m_fz0;
            m_sumx += fshift(longint'(signed'(dx)) * w, 16);
            m_sumz += fshift(longint'(signed'(dz)) * w, 16);
            m_ids[m_count] = it.idx;
            m_wts[m_count] = w;
            m_count++;
            return;
        end
        if (m_count != NPE) begin
            m_count = 0;
            r = '{it.idx, 32'd0, 32'd0, 48'd0, m_eacc[47:0], 1'b1, 1'b1};
            expected_forces.push_back(r);
            return;
        end
        m_count = 0;
        dx = it.px - m_fx0 - m_sumx[31:0];
        dz = it.pz - m_fz0 - m_sumz[31:0];
        sx = longint'(signed'(dx));
        sz = longint'(signed'(dz));
        drx = map_row(m_bxx, sx, m_bxz, sz);
        drz = map_row(m_bzx, sx, m_bzz, sz);
        ax = drx < 0 ? -drx : drx;
        az = drz < 0 ? -drz : drz;
        n2 = ax * ax + az * az;
        a = m_k * (n2 >> 32);
        b = m_k * (n2 & 64'hFFFF_FFFF);
        e = (a >> 1) + ((b + ((a & 1) << 32)) >> 33);
        if (e > 64'hFFFF_FFFF_FFFF) e = 64'hFFFF_FFFF_FFFF;
        m_eacc += e;
        if (m_eacc > 64'hFFFF_FFFF_FFFF) m_eacc = 64'hFFFF_FFFF_FFFF;
        fx = fshift(m_k * drx, 16);
        fz = fshift(m_k * drz, 16);
        r = '{it.idx, clamp32(-fx), clamp32(-fz), e[47:0], m_eacc[47:0], 1'b0, 1'b0};
        expected_forces.push_back(r);
        for (int j = 0; j < NPE; j++) begin
            r = '{m_ids[j], clamp32(fshift(fx * m_wts[j], 16)),
                  clamp32(fshift(fz * m_wts[j], 16)), e[47:0], m_eacc[47:0],
                  1'b0, j == NPE - 1};
            expected_forces.push_back(r);
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (in_valid && in_ready) predict_item(pending_items.pop_front());
        if (!(in_valid && !in_ready)) begin
            if (pending_items.size() > 0 && !send_paused
                && $urandom_range(99) >= send_idle) begin
                in_valid <= 1'b1;
                is_atom <= pending_items[0].is_atom;
                new_pass <= pending_items[0].new_pass;
                point_index <= pending_items[0].idx;
                pos_x <= pending_items[0].px;
                pos_z <= pending_items[0].pz;
                weight <= pending_items[0].w;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        force_t x;
        if (out_valid && out_ready) begin
            if (expected_forces.size() == 0) begin
                report_mismatch("unexpected result", point_index_res, 0);
            end else begin
                x = expected_forces.pop_front();
                if (point_index_res !== x.idx) report_mismatch("index", point_index_res, x.idx);
                if (force_x !== x.fx) report_mismatch("force_x", force_x, x.fx);
                if (force_z !== x.fz) report_mismatch("force_z", force_z, x.fz);
                if (anchor_energy !== x.e) report_mismatch("energy", anchor_energy, x.e);
                if (energy_total !== x.tot) report_mismatch("total", energy_total, x.tot);
                if (status !== x.st) report_mismatch("status", status, x.st);
                if (last !== x.lst) report_mismatch("last", last, x.lst);
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= $urandom_range(99) >= recv_idle;
        end
    end

    always @(posedge clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_BOX_XX: m_bxx = longint'(signed'(val));
            REG_BOX_XZ: m_bxz = longint'(signed'(val));
            REG_BOX_ZX: m_bzx = longint'(signed'(val));
            REG_BOX_ZZ: m_bzz = longint'(signed'(val));
            REG_SPRING: m_k = longint'(val[30:0]);
            default: ;
        endcase
        // idle wait so back to back writes never assign valid twice in a step
        @(posedge clk);
    endtask

    task automatic wait_drain();
        while (pending_items.size() > 0 || in_valid || expected_forces.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [18:0] rand_weight();
        case ($urandom_range(5))
            0: return 19'sd131072;
            1: return -19'sd131072;
            2: return 19'($urandom);
            default: return 19'($urandom_range(65536));
        endcase
    endfunction

    function automatic logic [31:0] rand_pos(logic [31:0] near);
        if ($urandom_range(3) == 0) return $urandom;
        return near + 32'($urandom_range(65535)) - 32'd32768;
    endfunction

    task automatic queue_anchor(int nodes, logic np, bit extreme);
        item_t it;
        logic [31:0] cx, cz;
        cx = $urandom;
        cz = $urandom;
        for (int n = 0; n < nodes; n++) begin
            it.is_atom = 0;
            it.new_pass = (n == 0) ? np : ($urandom_range(30) == 0);
            it.idx = 16'($urandom);
            it.px = extreme ? (n[0] ? 32'h8000_0000 : 32'h7FFF_FFFF) : rand_pos(cx);
            it.pz = extreme ? (n[0] ? 32'h7FFF_FFFF : 32'h8000_0000) : rand_pos(cz);
            it.w = extreme ? (n[0] ? 19'h3FFFF : 19'h40000) : rand_weight();
            pending_items.push_back(it);
        end
        it.is_atom = 1;
        it.new_pass = $urandom_range(20) == 0;
        it.idx = 16'($urandom);
        it.px = extreme ? 32'h8000_0000 : rand_pos(cx);
        it.pz = extreme ? 32'h7FFF_FFFF : rand_pos(cz);
        it.w = 19'($urandom);
        pending_items.push_back(it);
    endtask

    task automatic random_phase(int anchors);
        int nodes;
        for (int a = 0; a < anchors; a++) begin
            nodes = ($urandom_range(9) == 0) ? $urandom_range(NPE + 2) : NPE;
            queue_anchor(nodes, $urandom_range(6) == 0, 0);
        end
    endtask

    initial begin
        m_bxx = 65536; m_bxz = 0; m_bzx = 0; m_bzz = 65536; m_k = 65536;
        m_count = 0; m_sumx = 0; m_sumz = 0; m_fx0 = 0; m_fz0 = 0; m_eacc = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: defaults, wrong counts, extreme fields and weights
        queue_anchor(NPE, 1, 0);
        queue_anchor(0, 0, 0);
        queue_anchor(NPE - 1, 0, 0);
        queue_anchor(NPE + 2, 0, 0);
        queue_anchor(NPE, 0, 1);
        wait_drain();

        write_reg(REG_BOX_XX, 32'h7FFF_FFFF);
        write_reg(REG_BOX_XZ, 32'h8000_0000);
        write_reg(REG_BOX_ZX, 32'h7FFF_FFFF);
        write_reg(REG_BOX_ZZ, 32'h8000_0000);
        write_reg(REG_SPRING, 32'h7FFF_FFFF);
        queue_anchor(NPE, 0, 1);
        queue_anchor(NPE, 0, 0);
        queue_anchor(NPE, 0, 0);
        wait_drain();

        write_reg(REG_SPRING, 32'd0);
        queue_anchor(NPE, 1, 0);
        wait_drain();

        // random phases with different settings and idle mixes
        write_reg(REG_BOX_XX, 32'd65536 + $urandom_range(4096));
        write_reg(REG_BOX_XZ, $urandom_range(8192));
        write_reg(REG_BOX_ZX, -$urandom_range(8192));
        write_reg(REG_BOX_ZZ, 32'd131072);
        write_reg(REG_SPRING, 32'd65536 * $urandom_range(1, 20));
        random_phase(25);
        wait_drain();

        // long receiver hold while the sender keeps offering
        hold_cycles = 300;
        random_phase(5);
        wait_drain();

        send_idle = 85;
        recv_idle = 32;
        write_reg(REG_BOX_XX, $urandom);
        write_reg(REG_BOX_XZ, $urandom);
        write_reg(REG_BOX_ZX, $urandom);
        write_reg(REG_BOX_ZZ, $urandom);
        write_reg(REG_SPRING, $urandom);
        random_phase(25);
        wait_drain();

        send_idle = 0;
        recv_idle = 0;
        write_reg(REG_BOX_XX, 32'd65536);
        write_reg(REG_BOX_XZ, 32'd0);
        write_reg(REG_BOX_ZX, 32'd0);
        write_reg(REG_BOX_ZZ, 32'd65536);
        write_reg(REG_SPRING, 32'd1000000);
        random_phase(20);
        // sender pauses until every expected result is back
        while (pending_items.size() > 60) @(posedge clk);
        send_paused = 1;
        @(posedge clk);
        while (in_valid || expected_forces.size() > 0) @(posedge clk);
        send_paused = 0;
        wait_drain();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
